// ===== rtl/tccw_pkg.sv =====
`default_nettype none

package tccw_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int LINES   = 25;
  localparam int CELLS   = COLUMNS * LINES;

  // Field widths of the ports.
  localparam int CMD_W  = 1;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int LINE_W = 5;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  // Widths of the physical row index and of a store address.
  localparam int ROW_W  = $clog2(LINES);
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd10;

  localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_UNPRINT   = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_TILDE     = 8'h7E;

  localparam logic [CMD_W-1:0] CMD_PUT  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

  // Update of the per-row bookkeeping.
  typedef struct packed {
    logic              we;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  fill;
    logic              blank_we;
    logic [ATTR_W-1:0] blank_attr;
  } row_upd_t;

  // Registered answer of a row lookup.
  typedef struct packed {
    logic              from_mem;
    logic [CELL_W-1:0] blank_cell;
  } row_look_t;

endpackage

`default_nettype wire

// ===== rtl/text_console_cursor_writer_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    cmd, char_code, read_line, read_column
// output    out        out_valid / out_ready  cell_value, cursor_column, cursor_line, scrolled
// config    in         cfg_write_en           cfg_write_data (text attribute)
//
// Every request passes through S_IDLE and S_WAIT: the accept cycle drives the single
// store port, and S_WAIT collects the registered read data into the output register.
// A scroll needs no copying: lines are rotated by a top-of-screen pointer.
// Reset is synchronous and needs no clearing pass; per-row fill counts stand in
// for the cleared store. The next request is taken while a result waits.
// A stalled output holds the next request in S_WAIT, and no further request is taken.

module text_console_cursor_writer_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write_en,
  input  wire logic [tccw_pkg::ATTR_W-1:0] cfg_write_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [tccw_pkg::CMD_W-1:0]  cmd,
  input  wire logic [tccw_pkg::CHAR_W-1:0] char_code,
  input  wire logic [tccw_pkg::LINE_W-1:0] read_line,
  input  wire logic [tccw_pkg::COL_W-1:0]  read_column,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [tccw_pkg::CELL_W-1:0] cell_value,
  output logic      [tccw_pkg::COL_W-1:0]  cursor_column,
  output logic      [tccw_pkg::LINE_W-1:0] cursor_line,
  output logic                             scrolled
);
  import tccw_pkg::*;

  typedef enum logic {S_IDLE, S_WAIT} state_t;

  localparam logic [ROW_W:0]    LINES_X  = (ROW_W + 1)'(LINES);
  localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(LINES - 1);
  localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(LINES - 1);

  // Map a screen line onto a physical row of the store, given the top row.
  function automatic logic [ROW_W-1:0] row_of(input logic [ROW_W-1:0] t,
                                              input logic [ROW_W-1:0] l);
    logic [ROW_W:0] s;
    s = {1'b0, t} + {1'b0, l};
    return (s >= LINES_X) ? ROW_W'(s - LINES_X) : ROW_W'(s);
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

  state_t            state;
  logic [COL_W-1:0]  column;
  logic [LINE_W-1:0] line;
  logic [ROW_W-1:0]  top;
  logic [ATTR_W-1:0] attr;

  // Result fields held between the accept cycle and the output load.
  logic              res_from_store;
  logic [COL_W-1:0]  res_column;
  logic [LINE_W-1:0] res_line;
  logic              res_scrolled;

  logic              accept;
  logic              is_read;
  logic              is_put;
  logic              is_nl;
  logic              rd_ok;
  logic              wrap;
  logic              do_scroll;
  logic              do_write;
  logic [COL_W-1:0]  col_base;
  logic [COL_W-1:0]  column_next;
  logic [LINE_W-1:0] line_next;
  logic [ROW_W-1:0]  top_next;
  logic [CHAR_W-1:0] code;
  logic [ROW_W-1:0]  w_row;
  logic [ROW_W-1:0]  r_row;

  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [CELL_W-1:0] mem_rdata;
  row_upd_t          upd;
  row_look_t         look;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    is_read  = (cmd == CMD_READ);
    is_put   = (cmd == CMD_PUT) && (char_code != CH_NUL);
    is_nl    = (char_code == CH_NEWLINE);
    rd_ok    = (read_line < LINE_W'(LINES)) && (read_column < COL_W'(COLUMNS));

    // A newline, or a character arriving with the wrap pending, opens a new
    // line; from the bottom line that means rotating the screen up by one.
    wrap      = (column >= COL_W'(COLUMNS)) || is_nl;
    do_scroll = is_put && wrap && (line == LINE_LAST);
    do_write  = is_put && !is_nl;
    col_base  = wrap ? '0 : column;

    line_next   = (is_put && wrap && !do_scroll) ? line + 1'b1 : line;
    top_next    = do_scroll ? ((top == ROW_LAST) ? '0 : top + 1'b1) : top;
    column_next = !is_put ? column : (do_write ? col_base + 1'b1 : col_base);

    code = ((char_code >= CH_SPACE) && (char_code <= CH_TILDE)) ? char_code : CH_UNPRINT;

    w_row = row_of(top_next, ROW_W'(line_next));
    r_row = row_of(top, ROW_W'(read_line));

    mem_we   = accept && do_write;
    mem_re   = accept && is_read && rd_ok;
    mem_addr = is_read ? addr_of(r_row, read_column) : addr_of(w_row, col_base);

    // The row entered by a scroll starts over as blank spaces; the row under
    // the cursor always has a fill count equal to the cursor column.
    upd.we         = accept && is_put && (wrap || do_write);
    upd.row        = w_row;
    upd.fill       = do_write ? col_base + 1'b1 : '0;
    upd.blank_we   = accept && do_scroll;
    upd.blank_attr = attr;
  end

  tccw_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata ({attr, code}),
    .rdata (mem_rdata)
  );

  tccw_rows u_rows (
    .clk      (clk),
    .rst      (rst),
    .upd      (upd),
    .look_en  (accept && is_read),
    .look_row (r_row),
    .look_col (read_column),
    .look     (look)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      column    <= '0;
      line      <= '0;
      top       <= '0;
      attr      <= ATTR_RESET;
    end else begin
      if (cfg_write_en) begin
        attr <= cfg_write_data;
      end
      case (state)
        S_IDLE: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
          if (accept) begin
            column         <= column_next;
            line           <= line_next;
            top            <= top_next;
            res_from_store <= is_read && rd_ok;
            res_column     <= column_next;
            res_line       <= line_next;
            res_scrolled   <= do_scroll;
            state          <= S_WAIT;
          end
        end
        S_WAIT: begin
          // Load the result once the output register is free or being drained.
          if (!out_valid || out_ready) begin
            cell_value    <= !res_from_store ? '0 :
                             (look.from_mem ? mem_rdata : look.blank_cell);
            cursor_column <= res_column;
            cursor_line   <= res_line;
            scrolled      <= res_scrolled;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tccw_store.sv =====
`default_nettype none

module tccw_store (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic                        re,
  input  wire logic [tccw_pkg::ADDR_W-1:0] addr,
  input  wire logic [tccw_pkg::CELL_W-1:0] wdata,
  output logic      [tccw_pkg::CELL_W-1:0] rdata
);
  import tccw_pkg::*;

  logic [CELL_W-1:0] mem [CELLS];

  // Single port: a write or a registered read each cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tccw_rows.sv =====
`default_nettype none

module tccw_rows (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tccw_pkg::row_upd_t         upd,
  input  wire logic                       look_en,
  input  wire logic [tccw_pkg::ROW_W-1:0] look_row,
  input  wire logic [tccw_pkg::COL_W-1:0] look_col,
  output tccw_pkg::row_look_t             look
);
  import tccw_pkg::*;

  // Cells at or beyond a row's fill count have never been written since the
  // row was last blanked and read as that row's blank value.
  logic [COL_W-1:0]  fill   [LINES];
  logic              spaced [LINES];
  logic [ATTR_W-1:0] battr  [LINES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINES; i++) begin
        fill[i]   <= '0;
        spaced[i] <= 1'b0;
      end
    end else begin
      if (upd.we) begin
        fill[upd.row] <= upd.fill;
      end
      if (upd.blank_we) begin
        spaced[upd.row] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.blank_we) begin
      battr[upd.row] <= upd.blank_attr;
    end
  end

  always_ff @(posedge clk) begin
    if (look_en) begin
      look.from_mem   <= look_col < fill[look_row];
      look.blank_cell <= spaced[look_row] ? {battr[look_row], CH_SPACE} : '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tccw_checker.sv =====
`default_nettype none

module tccw_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [tccw_pkg::CELL_W-1:0] cell_value,
  input wire logic [tccw_pkg::COL_W-1:0]  cursor_column,
  input wire logic [tccw_pkg::LINE_W-1:0] cursor_line,
  input wire logic                        scrolled
);
  import tccw_pkg::*;

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_value)
      && $stable(cursor_column) && $stable(cursor_line) && $stable(scrolled))
    else $error("result changed while stalled");

  // Only one request is in flight at a time.
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cursor_line < LINE_W'(LINES)) && (cursor_column <= COL_W'(COLUMNS)))
    else $error("cursor out of range");

  // A scroll leaves the cursor on the bottom line at column 0 (newline) or 1 (character) and reads nothing.
  a_scroll_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && scrolled |-> (cursor_line == LINE_W'(LINES - 1))
      && (cursor_column <= COL_W'(1)) && (cell_value == '0))
    else $error("scroll result inconsistent");

endmodule

bind text_console_cursor_writer_unit tccw_checker u_tccw_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .cell_value    (cell_value),
  .cursor_column (cursor_column),
  .cursor_line   (cursor_line),
  .scrolled      (scrolled)
);

`default_nettype wire
